// ===== design/hbct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbct_pkg: shared types and constants of the buffer cache tag unit
// Geometry, field widths, command and status codes, the bucket row layout,
// and the reciprocal constants used by the constant divider.
// ----------------------------------------------------------------------------
package hbct_pkg;

  // Cache geometry
  localparam int NUM_BUCKETS     = 13;
  localparam int WAYS_PER_BUCKET = 5;
  localparam int SLOT_COUNT      = NUM_BUCKETS * WAYS_PER_BUCKET;

  // Field widths
  localparam int SLOT_W = 7;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int CNT_W  = 8;

  // Row address and way index widths
  localparam int ROW_AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_IW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

  // Constant divider: dividend, quotient, remainder and divisor widths
  localparam int DIVD_W      = 16;
  localparam int QUO_W       = 7;
  localparam int REM_W       = 6;
  localparam int DIVR_W      = 7;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = DIVD_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_BUCKETS = RECIP_W'((1 << RECIP_SHIFT) / NUM_BUCKETS);
  localparam logic [RECIP_W-1:0] RECIP_WAYS    = RECIP_W'((1 << RECIP_SHIFT) / WAYS_PER_BUCKET);
  localparam logic [DIVR_W-1:0]  DIVR_BUCKETS  = DIVR_W'(NUM_BUCKETS);
  localparam logic [DIVR_W-1:0]  DIVR_WAYS     = DIVR_W'(WAYS_PER_BUCKET);

  // Residues of 256^k modulo the bucket count, to fold the block number
  localparam int BYTE_WT1 = 256 % NUM_BUCKETS;
  localparam int BYTE_WT2 = (BYTE_WT1 * BYTE_WT1) % NUM_BUCKETS;
  localparam int BYTE_WT3 = (BYTE_WT2 * BYTE_WT1) % NUM_BUCKETS;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  // One way of a bucket row
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] cnt;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } way_t;

  typedef way_t [WAYS_PER_BUCKET-1:0] row_t;

  // Request context handed to the way update logic
  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [ROW_AW-1:0] bucket;
    logic [WAY_IW-1:0] way;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              need;
    status_t           status;
  } result_t;

  // Flat slot number of a bucket and way
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_AW-1:0] bucket,
                                                input logic [WAY_IW-1:0] way);
    slot_of = SLOT_W'(int'(bucket) * WAYS_PER_BUCKET + int'(way));
  endfunction

endpackage
`default_nettype wire

// ===== design/hbct_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbct_divider: two-stage divider by a fixed constant
// Divides by the bucket count or by the way count, chosen per request.
// Stage one estimates the quotient with a reciprocal multiply; stage two
// forms the remainder and corrects the estimate by one step.
// ----------------------------------------------------------------------------
module hbct_divider (
  input  wire                           clk,
  input  wire [hbct_pkg::DIVD_W-1:0]    dividend,
  input  wire                           by_ways,
  output logic [hbct_pkg::QUO_W-1:0]    quotient,
  output logic [hbct_pkg::REM_W-1:0]    remainder
);
  import hbct_pkg::*;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  product;
  logic [DIVD_W-1:0]  dvd1;
  logic [DIVD_W-1:0]  qest1;
  logic               sel1;
  logic [DIVR_W-1:0]  divisor;
  logic [DIVD_W-1:0]  back;
  logic [DIVD_W-1:0]  rem_raw;
  logic [DIVD_W-1:0]  rem_fix;
  logic [DIVD_W-1:0]  quo_fix;

  // Estimate the quotient, low by at most one
  always_comb begin
    recip   = by_ways ? RECIP_WAYS : RECIP_BUCKETS;
    product = PROD_W'(dividend) * PROD_W'(recip);
  end

  always_ff @(posedge clk) begin
    dvd1  <= dividend;
    sel1  <= by_ways;
    qest1 <= product[RECIP_SHIFT +: DIVD_W];
  end

  // Form the remainder and correct once
  always_comb begin
    divisor = sel1 ? DIVR_WAYS : DIVR_BUCKETS;
    back    = qest1 * DIVD_W'(divisor);
    rem_raw = dvd1 - back;
    if (rem_raw >= DIVD_W'(divisor)) begin
      rem_fix = rem_raw - DIVD_W'(divisor);
      quo_fix = qest1 + DIVD_W'(1);
    end else begin
      rem_fix = rem_raw;
      quo_fix = qest1;
    end
  end

  always_ff @(posedge clk) begin
    quotient  <= quo_fix[QUO_W-1:0];
    remainder <= rem_fix[REM_W-1:0];
  end

endmodule
`default_nettype wire

// ===== design/hbct_row_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbct_row_ram: one-read one-write row memory with clear on reset
// Read data is registered. A row valid bit per row, cleared by reset,
// makes an unwritten row read as all zero.
// ----------------------------------------------------------------------------
module hbct_row_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              rd_en,
  input  wire [AW-1:0]     rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  wire              wr_en,
  input  wire [AW-1:0]     wr_addr,
  input  wire [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written rows
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= row_vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// ===== design/hbct_way_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbct_way_update: tag compare and row update
// Compares all ways of a bucket row, picks the first match or first free
// way for a get, or adjusts one way's count, and builds the new row and
// the result.
// ----------------------------------------------------------------------------
module hbct_way_update (
  input  wire hbct_pkg::req_t   req,
  input  wire hbct_pkg::row_t   row_in,
  output hbct_pkg::row_t        row_out,
  output logic                  wr_en,
  output hbct_pkg::result_t     result
);
  import hbct_pkg::*;

  logic [WAYS_PER_BUCKET-1:0] match;
  logic [WAYS_PER_BUCKET-1:0] free;
  logic                       hit_found;
  logic                       free_found;
  logic [WAY_IW-1:0]          hit_way;
  logic [WAY_IW-1:0]          free_way;
  way_t                       hit_entry;
  way_t                       slot_entry;

  // Compare every way in parallel
  always_comb begin
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      match[w] = (row_in[w].dev == req.dev) && (row_in[w].blk == req.blk);
      free[w]  = (row_in[w].cnt == '0);
    end
  end

  // Pick the lowest matching and the lowest free way
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_found = 1'b1;
        hit_way   = WAY_IW'(w);
      end
      if (free[w]) begin
        free_found = 1'b1;
        free_way   = WAY_IW'(w);
      end
    end
  end

  assign hit_entry  = row_in[hit_way];
  assign slot_entry = row_in[req.way];

  // Build the new row and the result
  always_comb begin
    row_out       = row_in;
    wr_en         = 1'b0;
    result.slot   = req.slot;
    result.hit    = 1'b0;
    result.need   = 1'b0;
    result.status = ST_OK;
    unique case (req.cmd)
      CMD_GET: begin
        result.slot = '0;
        if (hit_found) begin
          wr_en                = 1'b1;
          result.slot          = slot_of(req.bucket, hit_way);
          result.hit           = 1'b1;
          result.need          = !hit_entry.vld;
          row_out[hit_way].vld = 1'b1;
          if (hit_entry.cnt == COUNT_MAX) begin
            result.status = ST_SATURATED;
          end else begin
            row_out[hit_way].cnt = hit_entry.cnt + CNT_W'(1);
          end
        end else if (free_found) begin
          wr_en             = 1'b1;
          result.slot       = slot_of(req.bucket, free_way);
          result.need       = 1'b1;
          row_out[free_way] = '{vld: 1'b1, cnt: CNT_W'(1), dev: req.dev, blk: req.blk};
        end else begin
          result.status = ST_NO_FREE;
        end
      end
      CMD_PIN: begin
        if (!req.slot_ok) begin
          result.status = ST_UNDERFLOW;
        end else if (slot_entry.cnt == COUNT_MAX) begin
          result.status = ST_SATURATED;
        end else begin
          wr_en                = 1'b1;
          row_out[req.way].cnt = slot_entry.cnt + CNT_W'(1);
        end
      end
      CMD_RELEASE, CMD_UNPIN: begin
        if (!req.slot_ok || slot_entry.cnt == '0) begin
          result.status = ST_UNDERFLOW;
        end else begin
          wr_en                = 1'b1;
          row_out[req.way].cnt = slot_entry.cnt - CNT_W'(1);
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/hashed_buffer_cache_tags_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_buffer_cache_tags_unit: tag and reference count engine of a
// hashed set-associative disk block cache
//
// Requests enter on req_valid/req_stall with command, device, block_number
// and slot_index; one result per request leaves on rsp_valid/rsp_stall
// with result_slot, hit, need_disk_read and status.
// A request is captured, passes the quotient and remainder stages of the
// constant divider that finds the bucket (or bucket and way of a slot), has
// its bucket row read, and then has the ways compared, the row written back
// and the result register loaded. The next request is taken only once the
// result register is loaded, so requests are not overlapped. The fixed
// sequence of divider, row read and write-back sets the rate; a new request
// waits until the previous row is written back.
// While a result waits in the output register, the next request is still
// taken and worked on; it holds in its update step, without writing the
// row, until the receiver takes the waiting result.
// Reset empties the output register and marks every bucket row as never
// written, so all tags and counts read as zero at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module hashed_buffer_cache_tags_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  output logic                          req_stall,
  input  wire [1:0]                     command,
  input  wire [hbct_pkg::DEV_W-1:0]     device,
  input  wire [hbct_pkg::BLK_W-1:0]     block_number,
  input  wire [hbct_pkg::SLOT_W-1:0]    slot_index,
  output logic                          rsp_valid,
  input  wire                           rsp_stall,
  output logic [hbct_pkg::SLOT_W-1:0]   result_slot,
  output logic                          hit,
  output logic                          need_disk_read,
  output logic [1:0]                    status
);
  import hbct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_REM,
    S_READ,
    S_UPDATE
  } state_t;

  localparam int ROW_BITS = $bits(row_t);

  state_t              state;
  cmd_t                cur_cmd;
  logic [DEV_W-1:0]    cur_dev;
  logic [BLK_W-1:0]    cur_blk;
  logic [SLOT_W-1:0]   cur_slot;
  logic [DIVD_W-1:0]   dividend;
  logic                by_ways;
  result_t             rsp_data;

  logic                accept;
  logic [DIVD_W-1:0]   hash_sum;
  logic [DIVD_W-1:0]   dividend_next;
  logic [QUO_W-1:0]    quotient;
  logic [REM_W-1:0]    remainder;
  logic                slot_ok;
  req_t                req;
  logic                ram_rd;
  logic                ram_wr;
  logic [ROW_BITS-1:0] ram_rd_data;
  row_t                row_new;
  logic                upd_wr;
  result_t             upd_result;
  logic                rsp_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // Fold the block number into a small value with the same bucket residue
  always_comb begin
    hash_sum = DIVD_W'(block_number[7:0])
             + DIVD_W'(block_number[15:8] * BYTE_WT1)
             + DIVD_W'(block_number[23:16] * BYTE_WT2)
             + DIVD_W'(block_number[31:24] * BYTE_WT3);
    dividend_next = (cmd_t'(command) == CMD_GET) ? hash_sum : DIVD_W'(slot_index);
  end

  hbct_divider u_divider (
    .clk       (clk),
    .dividend  (dividend),
    .by_ways   (by_ways),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Request context for the row read and update
  always_comb begin
    slot_ok     = int'(cur_slot) < SLOT_COUNT;
    req.cmd     = cur_cmd;
    req.slot    = cur_slot;
    req.slot_ok = slot_ok;
    req.dev     = cur_dev;
    req.blk     = cur_blk;
    if (cur_cmd == CMD_GET) begin
      req.bucket = remainder[ROW_AW-1:0];
      req.way    = '0;
    end else begin
      req.bucket = quotient[ROW_AW-1:0];
      req.way    = remainder[WAY_IW-1:0];
    end
  end

  assign ram_rd   = (state == S_READ) && ((cur_cmd == CMD_GET) || slot_ok);
  assign rsp_load = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);
  assign ram_wr   = rsp_load && upd_wr;

  hbct_row_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ram_rd),
    .rd_addr (req.bucket),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr),
    .wr_addr (req.bucket),
    .wr_data (row_new)
  );

  hbct_way_update u_way_update (
    .req     (req),
    .row_in  (row_t'(ram_rd_data)),
    .row_out (row_new),
    .wr_en   (upd_wr),
    .result  (upd_result)
  );

  // Sequence one request and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_QUOT;
          end
        end
        S_QUOT:   state <= S_REM;
        S_REM:    state <= S_READ;
        S_READ:   state <= S_UPDATE;
        S_UPDATE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_data  <= upd_result;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd  <= cmd_t'(command);
      cur_dev  <= device;
      cur_blk  <= block_number;
      cur_slot <= slot_index;
      dividend <= dividend_next;
      by_ways  <= (cmd_t'(command) != CMD_GET);
    end
  end

  assign result_slot    = rsp_data.slot;
  assign hit            = rsp_data.hit;
  assign need_disk_read = rsp_data.need;
  assign status         = rsp_data.status;

  // A transfer in starts the divider sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_QUOT)
    else $error("request transfer did not start the sequence");

  // Rows are written back only as the result is loaded
  a_write_with_load: assert property (@(posedge clk) disable iff (rst)
    ram_wr |-> (state == S_UPDATE && rsp_load))
    else $error("row write outside the update step");

  // A new result appears only out of the update step
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_UPDATE)
    else $error("result loaded outside the update step");

  // A stalled result holds the next request in its update step
  a_update_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && rsp_valid && rsp_stall) |=> state == S_UPDATE)
    else $error("update step left while the output register was full");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hashed_buffer_cache_tags_unit
// Walks a table of directed requests (reset tags, count underflow, slot out
// of range, full bucket, reclaim), then runs random request traffic with
// count saturation bursts. The expected result of every transfer comes from
// a tag and count predictor or from the table; results are compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import hbct_pkg::*;

  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_ITEMS = 1160;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    cmd_t              cmd;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    logic              typed;
    result_t           res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [1:0]          command = '0;
  logic [DEV_W-1:0]    device = '0;
  logic [BLK_W-1:0]    block_number = '0;
  logic [SLOT_W-1:0]   slot_index = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [SLOT_W-1:0]   result_slot;
  logic                hit;
  logic                need_disk_read;
  logic [1:0]          status;

  // Shadow copy of the tag store
  logic [DEV_W-1:0]    tag_dev   [SLOT_COUNT];
  logic [BLK_W-1:0]    tag_blk   [SLOT_COUNT];
  logic [CNT_W-1:0]    use_count [SLOT_COUNT];
  logic                slot_vld  [SLOT_COUNT];

  result_t             pending_results [$];
  result_t             want;
  stim_row_t           plan [DIRECTED_N];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  bit                  calm = 1'b0;

  hashed_buffer_cache_tags_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .command        (command),
    .device         (device),
    .block_number   (block_number),
    .slot_index     (slot_index),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_slot    (result_slot),
    .hit            (hit),
    .need_disk_read (need_disk_read),
    .status         (status)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow tag store and return its result
  function automatic result_t lookup_and_count(input cmd_t c, input logic [DEV_W-1:0] d,
                                               input logic [BLK_W-1:0] b,
                                               input logic [SLOT_W-1:0] s);
    result_t r;
    int      base;
    bit      done;
    r.slot   = '0;
    r.hit    = 1'b0;
    r.need   = 1'b0;
    r.status = ST_OK;
    if (c == CMD_GET) begin
      base = int'(b % 32'(NUM_BUCKETS)) * WAYS_PER_BUCKET;
      done = 1'b0;
      // look for a matching tag, valid or not
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
        if (!done && tag_dev[base+w] == d && tag_blk[base+w] == b) begin
          done   = 1'b1;
          r.slot = SLOT_W'(base + w);
          r.hit  = 1'b1;
          if (use_count[base+w] == COUNT_MAX) r.status = ST_SATURATED;
          else use_count[base+w] = use_count[base+w] + 1'b1;
          r.need = !slot_vld[base+w];
          slot_vld[base+w] = 1'b1;
        end
      end
      // claim the first unreferenced way
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
        if (!done && use_count[base+w] == '0) begin
          done   = 1'b1;
          r.slot = SLOT_W'(base + w);
          r.need = 1'b1;
          tag_dev[base+w]   = d;
          tag_blk[base+w]   = b;
          use_count[base+w] = CNT_W'(1);
          slot_vld[base+w]  = 1'b1;
        end
      end
      if (!done) r.status = ST_NO_FREE;
    end else begin
      r.slot = s;
      if (int'(s) >= SLOT_COUNT) begin
        r.status = ST_UNDERFLOW;
      end else if (c == CMD_PIN) begin
        if (use_count[s] == COUNT_MAX) r.status = ST_SATURATED;
        else use_count[s] = use_count[s] + 1'b1;
      end else begin
        if (use_count[s] == '0) r.status = ST_UNDERFLOW;
        else use_count[s] = use_count[s] - 1'b1;
      end
    end
    return r;
  endfunction

  // Offer one request, wait for the transfer, and queue its expected result
  task automatic send_request(input cmd_t c, input logic [DEV_W-1:0] d,
                              input logic [BLK_W-1:0] b, input logic [SLOT_W-1:0] s,
                              input logic typed, input result_t given,
                              output result_t predicted);
    if (!calm && $urandom_range(0, 99) < 13) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid    <= 1'b1;
    command      <= c;
    device       <= d;
    block_number <= b;
    slot_index   <= s;
    do @(posedge clk); while (req_stall);
    predicted = lookup_and_count(c, d, b, s);
    pending_results.push_back(typed ? given : predicted);
    @(negedge clk);
  endtask

  // Receiver stall
  always @(negedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: result_slot %0d status %0d", result_slot, status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, result_slot);
          mismatches++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          mismatches++;
        end
        if (need_disk_read !== want.need) begin
          $error("need_disk_read: expected %0d, got %0d", want.need, need_disk_read);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    result_t           pred;
    logic [DEV_W-1:0]  d;
    logic [BLK_W-1:0]  b;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] hot;
    logic [DEV_W-1:0]  hot_dev;
    logic [BLK_W-1:0]  hot_blk;
    cmd_t              c;
    int                r;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      tag_dev[i]   = '0;
      tag_blk[i]   = '0;
      use_count[i] = '0;
      slot_vld[i]  = 1'b0;
    end

    plan = '{
      // reset tag of device 0 block 0 hits way 0 of bucket 0, not yet valid
      '{CMD_GET,     8'd0,   32'd0,          7'd0,   1'b1, '{7'd0,   1'b1, 1'b1, ST_OK}},
      '{CMD_GET,     8'd0,   32'd0,          7'd127, 1'b1, '{7'd0,   1'b1, 1'b0, ST_OK}},
      '{CMD_RELEASE, 8'hA5,  32'h5A5A_5A5A,  7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_UNPIN,   8'h5A,  32'hA5A5_A5A5,  7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_OK}},
      // count underflow
      '{CMD_RELEASE, 8'd0,   32'd0,          7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_UNDERFLOW}},
      '{CMD_UNPIN,   8'd255, 32'hFFFF_FFFF,  7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_UNDERFLOW}},
      // slot out of range
      '{CMD_PIN,     8'd0,   32'd0,          7'd65,  1'b1, '{7'd65,  1'b0, 1'b0, ST_UNDERFLOW}},
      '{CMD_RELEASE, 8'd0,   32'd0,          7'd127, 1'b1, '{7'd127, 1'b0, 1'b0, ST_UNDERFLOW}},
      '{CMD_PIN,     8'd0,   32'd0,          7'd64,  1'b1, '{7'd64,  1'b0, 1'b0, ST_OK}},
      '{CMD_UNPIN,   8'd0,   32'd0,          7'd64,  1'b1, '{7'd64,  1'b0, 1'b0, ST_OK}},
      // largest tag lands in bucket 8
      '{CMD_GET,     8'd255, 32'hFFFF_FFFF,  7'd0,   1'b1, '{7'd40,  1'b0, 1'b1, ST_OK}},
      // fill bucket 1, then overflow it
      '{CMD_GET,     8'd1,   32'd1,          7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd14,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd27,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd40,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd53,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd66,         7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_NO_FREE}},
      '{CMD_GET,     8'd2,   32'd14,         7'd0,   1'b1, '{7'd0,   1'b0, 1'b0, ST_NO_FREE}},
      // free a way and reclaim it with another device
      '{CMD_RELEASE, 8'd0,   32'd0,          7'd7,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd2,   32'd14,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd1,   32'd14,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      // unreferenced but valid tag still hits
      '{CMD_GET,     8'd0,   32'd0,          7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd0,   32'd13,         7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_PIN,     8'd0,   32'd0,          7'd1,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}},
      '{CMD_GET,     8'd255, 32'hFFFF_FFFF,  7'd0,   1'b0, '{7'd0,   1'b0, 1'b0, ST_OK}}
    };

    // Hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_request(plan[i].cmd, plan[i].dev, plan[i].blk, plan[i].slot,
                   plan[i].typed, plan[i].res, pred);
    end

    // Random traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 900);

      // Drive a freshly claimed slot into count saturation, then hit it
      if (n == 300 || n == 1000) begin
        hot_dev = 8'($urandom);
        hot_blk = $urandom;
        send_request(CMD_GET, hot_dev, hot_blk, 7'($urandom), 1'b0, '0, pred);
        if (pred.status == ST_OK) begin
          hot = pred.slot;
          while (use_count[hot] != COUNT_MAX) begin
            send_request(CMD_PIN, 8'($urandom), $urandom, hot, 1'b0, '0, pred);
          end
          send_request(CMD_PIN, 8'($urandom), $urandom, hot, 1'b0, '0, pred);
          send_request(CMD_GET, hot_dev, hot_blk, 7'($urandom), 1'b0, '0, pred);
        end
      end

      r = $urandom_range(0, 99);
      d = 8'($urandom);
      b = $urandom;
      s = 7'($urandom);
      if (r < 40) begin
        c = CMD_GET;
        // mostly a small tag pool so that buckets fill and tags hit
        if ($urandom_range(0, 99) < 70) begin
          d = 8'($urandom_range(0, 2));
          b = 32'($urandom_range(0, 40));
        end
      end else begin
        if (r < 70) c = CMD_RELEASE;
        else if (r < 80) c = CMD_PIN;
        else c = CMD_UNPIN;
        // mostly referenced slots, sometimes any slot, some out of range
        if ($urandom_range(0, 99) >= 10) begin
          s = 7'($urandom_range(0, SLOT_COUNT - 1));
          for (int k = 0; k < 8 && r >= 25 && use_count[s] == '0; k++) begin
            s = 7'($urandom_range(0, SLOT_COUNT - 1));
          end
        end
      end
      send_request(c, d, b, s, 1'b0, '0, pred);
    end

    // Drain
    req_valid <= 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/hbct_pkg.sv
design/hbct_divider.sv
design/hbct_row_ram.sv
design/hbct_way_update.sv
design/hashed_buffer_cache_tags_unit.sv
tb/testbench.sv
